// ===== sv/dcl_pkg.sv =====
// Package for the discharge current limiter: widths, register codes,
// the divider sideband struct and the divider step function.
// No dependencies.
`default_nettype none

package dcl_pkg;

    localparam int PACKS      = 4;
    localparam int CUR_W      = 11;
    localparam int MV_W       = 13;
    localparam int MASK_W     = 4;
    localparam int PACK_IDX_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int SCALE_W    = 7;
    localparam int DIV_W      = MV_W + SCALE_W;
    localparam int SUM_W      = CUR_W + $clog2(PACKS);

    localparam logic [SCALE_W-1:0] PCT_SCALE = 7'd100;

    // configuration register codes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CUR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_CUR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PACK0     = 3'd4;

    typedef struct packed {
        logic             alarm;
        logic             bypass;
        logic             to_floor;
        logic [CUR_W-1:0] lim;
        logic [CUR_W-1:0] span;
        logic [DIV_W-1:0] num2;
    } dcl_side_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] nq;
    } dcl_div_st_t;

    // one restoring division step: shift in the next numerator bit,
    // subtract the divisor when it fits, shift the quotient bit in
    function automatic dcl_div_st_t div_step(input logic [DIV_W-1:0] rem,
                                             input logic [DIV_W-1:0] nq,
                                             input logic [DIV_W-1:0] den);
        logic [DIV_W:0] t;
        logic           q;
        dcl_div_st_t    r;
        t = {rem, nq[DIV_W-1]};
        q = (t >= {1'b0, den});
        if (q) begin
            t = t - {1'b0, den};
        end
        r.rem = t[DIV_W-1:0];
        r.nq  = {nq[DIV_W-2:0], q};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/dcl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// struct that travels alongside. Depends on dcl_pkg.
`default_nettype none

module dcl_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [dcl_pkg::DIV_W-1:0]     in_num,
    input  logic [dcl_pkg::DIV_W-1:0]     in_den,
    input  dcl_pkg::dcl_side_t            in_side,
    output logic                          out_valid,
    output logic [dcl_pkg::DIV_W-1:0]     out_quo,
    output dcl_pkg::dcl_side_t            out_side
);
    import dcl_pkg::*;

    logic [DIV_W-1:0] vld_reg;
    logic [DIV_W-1:0] vld_next;
    dcl_div_st_t      st_reg   [DIV_W];
    dcl_div_st_t      st_next  [DIV_W];
    logic [DIV_W-1:0] den_reg  [DIV_W];
    dcl_side_t        side_reg [DIV_W];

    always_comb begin
        vld_next[0] = in_valid;
        st_next[0]  = div_step('0, in_num, in_den);
        for (int i = 1; i < DIV_W; i++) begin
            vld_next[i] = vld_reg[i-1];
            st_next[i]  = div_step(st_reg[i-1].rem, st_reg[i-1].nq, den_reg[i-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0]   <= st_next[0];
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int i = 1; i < DIV_W; i++) begin
                st_reg[i]   <= st_next[i];
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[DIV_W-1];
    assign out_quo   = st_reg[DIV_W-1].nq;
    assign out_side  = side_reg[DIV_W-1];

endmodule

`default_nettype wire

// ===== sv/discharge_current_limiter.sv =====
// Discharge current limiter top level: config registers, pack summation,
// derating setup, two pipelined dividers and the output register.
// Depends on dcl_pkg and dcl_div.
//
//  channel   prefix  direction  transfer when
//  input     s_      in         s_valid & s_ready
//  result    m_      out        m_valid & m_ready
//  config    cfg_    in         cfg_valid & cfg_ready (always ready)
//
// Pipeline: input/sum stage, derate setup stage, 20 stages of the step
// divider, 20 stages of the drop divider, output register.
// One update is accepted every cycle while the output is not stalled;
// throughput is set by the single global advance enable shared by all stages.
// Reset clears every valid bit and the config registers; data regs are not reset.
// When a result sits in the output register and m_ready is low, the whole
// pipe holds and s_ready drops; nothing is lost or duplicated.
`default_nettype none

module discharge_current_limiter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_alarm_zero,
    input  logic [dcl_pkg::PACK_IDX_W-1:0]    s_primary_pack,
    input  logic [dcl_pkg::MASK_W-1:0]        s_extra_pack_mask,
    input  logic [dcl_pkg::MASK_W-1:0]        s_error_free_mask,
    input  logic [dcl_pkg::MASK_W-1:0]        s_fresh_mask,
    input  logic [dcl_pkg::MASK_W-1:0]        s_fet_on_mask,
    input  logic [dcl_pkg::MV_W-1:0]          s_min_cell_mv,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dcl_pkg::CUR_W-1:0]         m_discharge_current,
    output logic [dcl_pkg::CUR_W-1:0]         m_voltage_limited_current,
    // config channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dcl_pkg::*;

    // ---------------- config registers ----------------
    logic [CUR_W-1:0] max_cur_reg;
    logic [MV_W-1:0]  start_mv_reg;
    logic [MV_W-1:0]  end_mv_reg;
    logic [CUR_W-1:0] floor_cur_reg;
    logic [CUR_W-1:0] pack_cur_reg [PACKS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_cur_reg   <= '0;
            start_mv_reg  <= '0;
            end_mv_reg    <= '0;
            floor_cur_reg <= '0;
            for (int i = 0; i < PACKS; i++) begin
                pack_cur_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_CUR:   max_cur_reg   <= cfg_data[CUR_W-1:0];
                REG_START_MV:  start_mv_reg  <= cfg_data[MV_W-1:0];
                REG_END_MV:    end_mv_reg    <= cfg_data[MV_W-1:0];
                REG_FLOOR_CUR: floor_cur_reg <= cfg_data[CUR_W-1:0];
                default: begin
                    // pack currents; indexes past the last pack are dropped
                    for (int i = 0; i < PACKS; i++) begin
                        if (cfg_index == REG_PACK0 + CFG_IDX_W'(i)) begin
                            pack_cur_reg[i] <= cfg_data[CUR_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // ---------------- global advance ----------------
    logic adv;
    assign adv     = m_ready || !m_valid;
    assign s_ready = adv;

    // ---------------- stage 1: pack sum and clamp ----------------
    logic [MASK_W-1:0] healthy;
    logic [SUM_W-1:0]  pack_sum;
    logic [CUR_W-1:0]  lim_s0;

    always_comb begin
        healthy  = s_error_free_mask & s_fresh_mask & s_fet_on_mask;
        pack_sum = '0;
        for (int i = 0; i < PACKS; i++) begin
            if ((s_primary_pack == PACK_IDX_W'(i) || s_extra_pack_mask[i]) && healthy[i]) begin
                pack_sum = pack_sum + SUM_W'(pack_cur_reg[i]);
            end
        end
        lim_s0 = max_cur_reg;
        if (s_extra_pack_mask != '0 && pack_sum < SUM_W'(max_cur_reg)) begin
            lim_s0 = pack_sum[CUR_W-1:0];
        end
    end

    logic             s1_vld_reg;
    logic             s1_alarm_reg;
    logic [CUR_W-1:0] s1_lim_reg;
    logic [MV_W-1:0]  s1_cell_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_alarm_reg <= s_alarm_zero;
            s1_lim_reg   <= lim_s0;
            s1_cell_reg  <= s_min_cell_mv;
        end
    end

    // ---------------- stage 2: derating setup ----------------
    // bypass: derating off, cell above start, empty ramp, or limit already at/below floor
    dcl_side_t        side_s1;
    logic [DIV_W-1:0] num1_s1;

    always_comb begin
        side_s1.alarm    = s1_alarm_reg;
        side_s1.bypass   = (start_mv_reg == '0) || (start_mv_reg < s1_cell_reg)
                        || (start_mv_reg <= end_mv_reg) || (s1_lim_reg <= floor_cur_reg);
        side_s1.to_floor = (s1_cell_reg < end_mv_reg);
        side_s1.lim      = s1_lim_reg;
        side_s1.span     = s1_lim_reg - floor_cur_reg;
        side_s1.num2     = (DIV_W'(start_mv_reg) - DIV_W'(s1_cell_reg)) * DIV_W'(PCT_SCALE);
        num1_s1          = (DIV_W'(start_mv_reg) - DIV_W'(end_mv_reg)) * DIV_W'(PCT_SCALE);
    end

    logic             s2_vld_reg;
    logic [DIV_W-1:0] s2_num1_reg;
    dcl_side_t        s2_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_num1_reg <= num1_s1;
            s2_side_reg <= side_s1;
        end
    end

    // ---------------- step = (start - end) * 100 / span ----------------
    logic             d1_vld;
    logic [DIV_W-1:0] d1_quo;
    dcl_side_t        d1_side;

    dcl_div u_div_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s2_vld_reg),
        .in_num    (s2_num1_reg),
        .in_den    (DIV_W'(s2_side_reg.span)),
        .in_side   (s2_side_reg),
        .out_valid (d1_vld),
        .out_quo   (d1_quo),
        .out_side  (d1_side)
    );

    // zero step means the ramp collapses to the floor
    dcl_side_t side_d1;
    always_comb begin
        side_d1          = d1_side;
        side_d1.to_floor = d1_side.to_floor || (d1_quo == '0);
    end

    // ---------------- drop = (start - cell) * 100 / step ----------------
    logic             d2_vld;
    logic [DIV_W-1:0] d2_quo;
    dcl_side_t        d2_side;

    dcl_div u_div_drop (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (d1_vld),
        .in_num    (d1_side.num2),
        .in_den    (d1_quo),
        .in_side   (side_d1),
        .out_valid (d2_vld),
        .out_quo   (d2_quo),
        .out_side  (d2_side)
    );

    // ---------------- final select and output register ----------------
    logic [CUR_W-1:0] res_d2;
    always_comb begin
        if (d2_side.alarm) begin
            res_d2 = '0;
        end else if (d2_side.bypass) begin
            res_d2 = d2_side.lim;
        end else if (d2_side.to_floor || d2_quo > DIV_W'(d2_side.span)) begin
            res_d2 = floor_cur_reg;
        end else begin
            res_d2 = d2_side.lim - d2_quo[CUR_W-1:0];
        end
    end

    logic             m_vld_reg;
    logic [CUR_W-1:0] m_cur_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= d2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_cur_reg <= res_d2;
        end
    end

    assign m_valid                   = m_vld_reg;
    assign m_discharge_current       = m_cur_reg;
    assign m_voltage_limited_current = m_cur_reg;

    // ---------------- assertions ----------------
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_fields_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_discharge_current == m_voltage_limited_current))
        else $error("result fields differ");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ===== dv/discharge_current_limiter_checker.sv =====
// Checker for the discharge current limiter: follows the config, input and
// result channels, predicts each allowed current and compares it in order.
// Depends on dcl_pkg.
module discharge_current_limiter_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_alarm_zero,
    input  logic [dcl_pkg::PACK_IDX_W-1:0] s_primary_pack,
    input  logic [dcl_pkg::MASK_W-1:0]     s_extra_pack_mask,
    input  logic [dcl_pkg::MASK_W-1:0]     s_error_free_mask,
    input  logic [dcl_pkg::MASK_W-1:0]     s_fresh_mask,
    input  logic [dcl_pkg::MASK_W-1:0]     s_fet_on_mask,
    input  logic [dcl_pkg::MV_W-1:0]       s_min_cell_mv,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [dcl_pkg::CUR_W-1:0]      m_discharge_current,
    input  logic [dcl_pkg::CUR_W-1:0]      m_voltage_limited_current,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [dcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcl_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             limits_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dcl_pkg::*;

    localparam int PIDX_W = $clog2(PACKS);

    typedef struct packed {
        logic [CUR_W-1:0] discharge;
        logic [CUR_W-1:0] volt_limited;
    } current_pair_t;

    // shadow copy of the config registers
    logic [CUR_W-1:0] max_cur;
    logic [MV_W-1:0]  start_mv;
    logic [MV_W-1:0]  end_mv;
    logic [CUR_W-1:0] floor_cur;
    logic [CUR_W-1:0] pack_cur [PACKS];

    current_pair_t pending_limits [$];

    task automatic flag(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // linear derating by minimum cell voltage
    function automatic logic [CUR_W-1:0] derated_current(input logic [CUR_W-1:0] lim,
                                                         input logic [MV_W-1:0]  cell_mv);
        logic [CUR_W-1:0] span;
        logic [DIV_W-1:0] ramp_step;
        logic [DIV_W-1:0] drop;
        if (start_mv == 0 || start_mv < cell_mv) return lim;
        if (start_mv <= end_mv) return lim;
        if (lim <= floor_cur) return lim;
        if (cell_mv < end_mv) return floor_cur;
        span      = lim - floor_cur;
        ramp_step = DIV_W'(start_mv - end_mv) * DIV_W'(PCT_SCALE) / DIV_W'(span);
        if (ramp_step == 0) return floor_cur;
        drop = DIV_W'(start_mv - cell_mv) * DIV_W'(PCT_SCALE) / ramp_step;
        if (drop > DIV_W'(span)) return floor_cur;
        return lim - drop[CUR_W-1:0];
    endfunction

    function automatic logic [CUR_W-1:0] allowed_current(
        input logic                  alarm,
        input logic [PACK_IDX_W-1:0] primary,
        input logic [MASK_W-1:0]     extra,
        input logic [MASK_W-1:0]     okerr,
        input logic [MASK_W-1:0]     fresh,
        input logic [MASK_W-1:0]     fet,
        input logic [MV_W-1:0]       cell_mv
    );
        logic [SUM_W-1:0]  pack_sum;
        logic [MASK_W-1:0] healthy;
        logic [CUR_W-1:0]  lim;
        int                i;
        if (alarm) return '0;
        lim = max_cur;
        if (extra != 0) begin
            pack_sum = '0;
            healthy  = okerr & fresh & fet;
            for (i = 0; i < PACKS; i++) begin
                if ((primary == i || extra[i]) && healthy[i]) begin
                    pack_sum += SUM_W'(pack_cur[i]);
                end
            end
            if (pack_sum < SUM_W'(lim)) lim = pack_sum[CUR_W-1:0];
        end
        return derated_current(lim, cell_mv);
    endfunction

    always @(posedge aclk) begin : watch
        current_pair_t want;
        int            k;
        if (!aresetn) begin
            max_cur   <= '0;
            start_mv  <= '0;
            end_mv    <= '0;
            floor_cur <= '0;
            for (k = 0; k < PACKS; k++) begin
                pack_cur[k] <= '0;
            end
            pending_limits.delete();
            limits_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAX_CUR:   max_cur   <= cfg_data[CUR_W-1:0];
                    REG_START_MV:  start_mv  <= cfg_data[MV_W-1:0];
                    REG_END_MV:    end_mv    <= cfg_data[MV_W-1:0];
                    REG_FLOOR_CUR: floor_cur <= cfg_data[CUR_W-1:0];
                    default: begin
                        pack_cur[PIDX_W'(cfg_index - REG_PACK0)] <= cfg_data[CUR_W-1:0];
                    end
                endcase
            end
            // results first, so a stray result never meets this edge's prediction
            if (m_valid && m_ready) begin
                if (pending_limits.size() == 0) begin
                    flag($sformatf("result %0d/%0d with nothing expected",
                                   m_discharge_current, m_voltage_limited_current));
                end else begin
                    want = pending_limits.pop_front();
                    if (m_discharge_current !== want.discharge) begin
                        flag($sformatf("discharge_current got %0d exp %0d",
                                       m_discharge_current, want.discharge));
                    end
                    if (m_voltage_limited_current !== want.volt_limited) begin
                        flag($sformatf("voltage_limited_current got %0d exp %0d",
                                       m_voltage_limited_current, want.volt_limited));
                    end
                end
            end
            if (s_valid && s_ready) begin
                want.discharge    = allowed_current(s_alarm_zero, s_primary_pack,
                                                    s_extra_pack_mask, s_error_free_mask,
                                                    s_fresh_mask, s_fet_on_mask,
                                                    s_min_cell_mv);
                want.volt_limited = want.discharge;
                pending_limits.push_back(want);
            end
            limits_pending <= pending_limits.size();
        end
    end

endmodule

// ===== dv/discharge_current_limiter_tb.sv =====
// Testbench top for the discharge current limiter: clock, reset, config
// writes, update stimulus and result-side backpressure, plus the verdict.
// Depends on dcl_pkg, discharge_current_limiter and its checker.
module discharge_current_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcl_pkg::*;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic                  s_alarm_zero      = 1'b0;
    logic [PACK_IDX_W-1:0] s_primary_pack    = '0;
    logic [MASK_W-1:0]     s_extra_pack_mask = '0;
    logic [MASK_W-1:0]     s_error_free_mask = '0;
    logic [MASK_W-1:0]     s_fresh_mask      = '0;
    logic [MASK_W-1:0]     s_fet_on_mask     = '0;
    logic [MV_W-1:0]       s_min_cell_mv     = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CUR_W-1:0]      m_discharge_current;
    logic [CUR_W-1:0]      m_voltage_limited_current;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    mismatches;
    int                    limits_pending;

    // per-phase idle switches for sender and receiver
    bit                    tx_idle  = 1'b1;
    bit                    rx_idle  = 1'b1;
    // set by the stimulus, cleared by the receiver when it starts the hold-off
    bit                    hold_req = 1'b0;

    // stimulus-side view of the derating window, used to aim cell voltages
    logic [MV_W-1:0]       win_start = '0;
    logic [MV_W-1:0]       win_end   = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    discharge_current_limiter u_dut (
        .aclk                      (aclk),
        .aresetn                   (aresetn),
        .s_valid                   (s_valid),
        .s_ready                   (s_ready),
        .s_alarm_zero              (s_alarm_zero),
        .s_primary_pack            (s_primary_pack),
        .s_extra_pack_mask         (s_extra_pack_mask),
        .s_error_free_mask         (s_error_free_mask),
        .s_fresh_mask              (s_fresh_mask),
        .s_fet_on_mask             (s_fet_on_mask),
        .s_min_cell_mv             (s_min_cell_mv),
        .m_valid                   (m_valid),
        .m_ready                   (m_ready),
        .m_discharge_current       (m_discharge_current),
        .m_voltage_limited_current (m_voltage_limited_current),
        .cfg_valid                 (cfg_valid),
        .cfg_ready                 (cfg_ready),
        .cfg_index                 (cfg_index),
        .cfg_data                  (cfg_data)
    );

    discharge_current_limiter_checker u_checker (
        .aclk                      (aclk),
        .aresetn                   (aresetn),
        .s_valid                   (s_valid),
        .s_ready                   (s_ready),
        .s_alarm_zero              (s_alarm_zero),
        .s_primary_pack            (s_primary_pack),
        .s_extra_pack_mask         (s_extra_pack_mask),
        .s_error_free_mask         (s_error_free_mask),
        .s_fresh_mask              (s_fresh_mask),
        .s_fet_on_mask             (s_fet_on_mask),
        .s_min_cell_mv             (s_min_cell_mv),
        .m_valid                   (m_valid),
        .m_ready                   (m_ready),
        .m_discharge_current       (m_discharge_current),
        .m_voltage_limited_current (m_voltage_limited_current),
        .cfg_valid                 (cfg_valid),
        .cfg_ready                 (cfg_ready),
        .cfg_index                 (cfg_index),
        .cfg_data                  (cfg_data),
        .mismatches                (mismatches),
        .limits_pending            (limits_pending)
    );

    // One config transfer. Valid stays up so back-to-back writes need no gap;
    // the caller drops it after the last register.
    task automatic cfg_put(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Rewrites the whole register file. Only called with the pipe empty.
    task automatic write_regs(input logic [CFG_DATA_W-1:0] max_a,
                              input logic [CFG_DATA_W-1:0] start_v,
                              input logic [CFG_DATA_W-1:0] stop_v,
                              input logic [CFG_DATA_W-1:0] floor_a,
                              input logic [CFG_DATA_W-1:0] p0,
                              input logic [CFG_DATA_W-1:0] p1,
                              input logic [CFG_DATA_W-1:0] p2,
                              input logic [CFG_DATA_W-1:0] p3);
        cfg_put(REG_MAX_CUR,   max_a);
        cfg_put(REG_START_MV,  start_v);
        cfg_put(REG_END_MV,    stop_v);
        cfg_put(REG_FLOOR_CUR, floor_a);
        cfg_put(REG_PACK0,              p0);
        cfg_put(REG_PACK0 + 3'd1,       p1);
        cfg_put(REG_PACK0 + 3'd2,       p2);
        cfg_put(REG_PACK0 + 3'd3,       p3);
        cfg_valid <= 1'b0;
        win_start = start_v;
        win_end   = stop_v;
    endtask

    // One update transfer, preceded by a random gap when the sender idles.
    // Valid is only dropped on the gap path, so a zero gap keeps it high.
    task automatic send_update(input logic                  alarm,
                               input logic [PACK_IDX_W-1:0] primary,
                               input logic [MASK_W-1:0]     extra,
                               input logic [MASK_W-1:0]     okerr,
                               input logic [MASK_W-1:0]     fresh,
                               input logic [MASK_W-1:0]     fet,
                               input logic [MV_W-1:0]       cell_mv);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_alarm_zero      <= alarm;
        s_primary_pack    <= primary;
        s_extra_pack_mask <= extra;
        s_error_free_mask <= okerr;
        s_fresh_mask      <= fresh;
        s_fet_on_mask     <= fet;
        s_min_cell_mv     <= cell_mv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering and wait until every predicted result has come back.
    // The first edge lets the last transfer show up in the pending count.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (limits_pending != 0);
    endtask

    // current values lean on the extremes
    function automatic logic [CFG_DATA_W-1:0] pick_current();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return CFG_DATA_W'(2047);
            default: return CFG_DATA_W'($urandom_range(0, 2047));
        endcase
    endfunction

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] start_v;
        logic [CFG_DATA_W-1:0] stop_v;
        logic [CFG_DATA_W-1:0] floor_a;
        case ($urandom_range(0, 9))
            0:       start_v = '0;
            1:       start_v = CFG_DATA_W'(8191);
            default: start_v = CFG_DATA_W'($urandom_range(200, 8191));
        endcase
        case ($urandom_range(0, 9))
            0:       stop_v = start_v;                                  // empty window
            1:       stop_v = CFG_DATA_W'($urandom_range(0, 8191));     // anything
            2:       stop_v = '0;
            default: stop_v = (start_v > 0) ? CFG_DATA_W'($urandom_range(0, start_v - 1))
                                            : CFG_DATA_W'($urandom_range(0, 8191));
        endcase
        floor_a = ($urandom_range(0, 2) == 0) ? pick_current()
                                              : CFG_DATA_W'($urandom_range(0, 600));
        write_regs(pick_current(), start_v, stop_v, floor_a,
                   pick_current(), pick_current(), pick_current(), pick_current());
    endtask

    task automatic send_random_update();
        logic [MV_W-1:0]       cell_mv;
        logic [PACK_IDX_W-1:0] primary;
        int                    lo;
        int                    hi;
        // most cells land in or near the derating window
        if (win_start == 0 || $urandom_range(0, 3) == 0) begin
            cell_mv = MV_W'($urandom_range(0, 8191));
        end else begin
            lo   = (win_end > 150) ? win_end - 150 : 0;
            hi   = (win_start < 8041) ? win_start + 150 : 8191;
            if (lo > hi) lo = 0;
            cell_mv = MV_W'($urandom_range(lo, hi));
        end
        primary = ($urandom_range(0, 3) == 0) ? PACK_IDX_W'($urandom_range(0, 15))
                                              : PACK_IDX_W'($urandom_range(0, PACKS));
        // health masks are mostly all-good so the sum actually matters
        send_update($urandom_range(0, 9) == 0,
                    primary,
                    MASK_W'($urandom_range(0, 15)),
                    ($urandom_range(0, 3) == 0) ? MASK_W'($urandom_range(0, 15)) : '1,
                    ($urandom_range(0, 3) == 0) ? MASK_W'($urandom_range(0, 15)) : '1,
                    ($urandom_range(0, 3) == 0) ? MASK_W'($urandom_range(0, 15)) : '1,
                    cell_mv);
    endtask

    // Result side: a fresh wait per result, plus one long hold-off on request
    // so the pipe backs up into s_ready.
    initial begin : result_sink
        int wait_cycles;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            wait_cycles = rx_idle ? $urandom_range(0, 14) : 0;
            if (hold_req) begin
                hold_req    = 1'b0;
                wait_cycles = 600;
            end
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int phase;
        int n;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: alarm, pack selection and health, derating window ---
        write_regs(13'd2047, 13'd3600, 13'd3000, 13'd100,
                   13'd500, 13'd700, 13'd900, 13'd1100);
        send_update(1'b1, 4'd15, 4'hF, 4'hF, 4'hF, 4'hF, 13'd8191); // alarm forces zero
        send_update(1'b0, 4'd0,  4'h0, 4'h0, 4'h0, 4'h0, 13'd8191); // no pack sum, no derate
        send_update(1'b0, 4'd0,  4'hF, 4'hF, 4'hF, 4'hF, 13'd8191); // sum above max
        send_update(1'b0, 4'd15, 4'h1, 4'hF, 4'hF, 4'hF, 13'd8191); // no primary, one extra
        send_update(1'b0, 4'd0,  4'h2, 4'hF, 4'hF, 4'hF, 13'd8191); // primary plus extra
        send_update(1'b0, 4'd4,  4'h8, 4'hF, 4'hF, 4'hF, 13'd8191); // primary index == PACKS
        send_update(1'b0, 4'd0,  4'hF, 4'h0, 4'hF, 4'hF, 13'd8191); // all packs in error
        send_update(1'b0, 4'd0,  4'hF, 4'hF, 4'h5, 4'hF, 13'd8191); // stale packs dropped
        send_update(1'b0, 4'd0,  4'hF, 4'hF, 4'hF, 4'hA, 13'd8191); // FETs off dropped
        send_update(1'b0, 4'd0,  4'h0, 4'h0, 4'h0, 4'h0, 13'd3600); // cell at start
        send_update(1'b0, 4'd0,  4'h0, 4'h0, 4'h0, 4'h0, 13'd3300); // mid ramp
        send_update(1'b0, 4'd0,  4'h0, 4'h0, 4'h0, 4'h0, 13'd3000); // cell at end
        send_update(1'b0, 4'd0,  4'h0, 4'h0, 4'h0, 4'h0, 13'd2999); // below end -> floor
        send_update(1'b0, 4'd0,  4'h0, 4'h0, 4'h0, 4'h0, 13'd0);
        send_update(1'b0, 4'd1,  4'h8, 4'hF, 4'hF, 4'hF, 13'd3400); // summed then derated
        drain_results();

        // truncated ramp step lets the drop overshoot the span
        write_regs(13'd1500, 13'd1000, 13'd0, 13'd0,
                   13'd2047, 13'd2047, 13'd2047, 13'd2047);
        send_update(1'b0, 4'd0, 4'h0, 4'h0, 4'h0, 4'h0, 13'd0);
        send_update(1'b0, 4'd0, 4'h0, 4'h0, 4'h0, 4'h0, 13'd1000);
        send_update(1'b0, 4'd0, 4'hF, 4'hF, 4'hF, 4'hF, 13'd500);
        drain_results();

        // one-millivolt window: the ramp step rounds to zero
        write_regs(13'd2047, 13'd101, 13'd100, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
        send_update(1'b0, 4'd0, 4'h0, 4'h0, 4'h0, 4'h0, 13'd100);
        send_update(1'b0, 4'd0, 4'h0, 4'h0, 4'h0, 4'h0, 13'd101);
        send_update(1'b0, 4'd0, 4'hF, 4'hF, 4'hF, 4'hF, 13'd100); // limit at floor
        drain_results();

        // derating disabled, zero max, floor at top
        write_regs(13'd0, 13'd0, 13'd8191, 13'd2047,
                   13'd2047, 13'd2047, 13'd2047, 13'd2047);
        send_update(1'b0, 4'd0, 4'hF, 4'hF, 4'hF, 4'hF, 13'd0);
        drain_results();

        // start equal to end passes through
        write_regs(13'd2047, 13'd3000, 13'd3000, 13'd0, 13'd1, 13'd2, 13'd3, 13'd4);
        send_update(1'b0, 4'd0, 4'h0, 4'h0, 4'h0, 4'h0, 13'd2000);
        drain_results();

        // widest window
        write_regs(13'd2047, 13'd8191, 13'd0, 13'd0,
                   13'd2047, 13'd2047, 13'd2047, 13'd2047);
        send_update(1'b0, 4'd0, 4'h0, 4'h0, 4'h0, 4'h0, 13'd8191);
        send_update(1'b0, 4'd0, 4'h0, 4'h0, 4'h0, 4'h0, 13'd4095);
        send_update(1'b0, 4'd0, 4'h0, 4'h0, 4'h0, 4'h0, 13'd0);
        drain_results();

        // --- random: eight config phases, every idle combination ---
        for (phase = 0; phase < 8; phase++) begin
            tx_idle = phase[0];
            rx_idle = phase[1];
            random_setup();
            // long receiver stall while the sender streams without gaps
            if (phase == 2 || phase == 6) hold_req = 1'b1;
            for (n = 0; n < 100; n++) begin
                send_random_update();
            end
            drain_results();
        end

        // let any stray result surface from the pipe
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
